// ===== src/fhs_pkg.sv =====
// Shared types and constants for the five-point heat stencil.
// Holds sample, line-buffer and configuration widths plus the pipeline stage record.
// No dependencies.
package fhs_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int SAMPLE_BITS  = 32;
  localparam int SUM_BITS     = SAMPLE_BITS + 2;
  localparam int WEIGHT_BITS  = 17;
  localparam int PROD_C_BITS  = WEIGHT_BITS + 1 + SAMPLE_BITS;
  localparam int PROD_N_BITS  = WEIGHT_BITS + 1 + SUM_BITS;
  localparam int ACC_BITS     = PROD_N_BITS + 1;
  localparam int FRAC_SHIFT   = 18;
  localparam int SHIFTED_BITS = ACC_BITS - FRAC_SHIFT;

  localparam int WIDTH_BITS   = 11;
  localparam int HEIGHT_BITS  = 16;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = WEIGHT_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PLANE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PLANE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA_WEIGHT = 2'd2;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [WIDTH_BITS-1:0]  WIDTH_MIN    = 11'd3;
  localparam logic [WIDTH_BITS-1:0]  WIDTH_MAX    = WIDTH_BITS'(MAX_WIDTH);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd1024;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN   = 16'd3;
  localparam logic [WEIGHT_BITS-1:0] ALPHA_RESET  = 17'd32768;
  localparam logic [WEIGHT_BITS-1:0] ALPHA_ONE    = 17'd65536;

  // sample waiting for its line-buffer read data
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] bottom;
    logic [COL_BITS-1:0]           col;
    logic                          produce;
    logic                          last;
  } mem_stage_t;

endpackage

// ===== src/five_point_heat_stencil.sv =====
// Five-point Jacobi heat stencil over a streamed padded plane.
// Two line-buffer memories, a stencil window and a three-stage arithmetic pipeline.
// Depends on fhs_pkg.
//
// Usage:
//   s_tdata carries one signed Q16.16 sample per transfer, padded plane in raster
//   order (halo included). For each interior cell one result leaves on m_tdata,
//   m_tlast set on the final interior cell of the plane; halo samples give none.
//   The cfg channel (index, data) sets plane_width (0), plane_height (1) and
//   alpha_weight (2); width or height writes restart the plane. Write it idle only.
// Throughput: one sample per clock unless stalled, limited by the single read and
//   write port of each line-buffer memory, which is touched once per sample.
// Pipeline: the sample that completes a neighborhood passes stage 1 (memory read),
//   stage 2 (operand add), stage 3 (multiply), then round into the output register.
// Reset: counters, window and valid flags clear; registers go to width 1024,
//   height 1024, alpha one half. Line buffers are not cleared.
// Stall: stages hold their contents while m_tready is low; empty stages in front
//   keep taking samples until the pipeline fills, then s_tready drops.
module five_point_heat_stencil import fhs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [SAMPLE_BITS-1:0]    s_tdata,    // [31:0] sample
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [SAMPLE_BITS-1:0]    m_tdata,    // [31:0] new_value
  output logic                      m_tlast,    // is_last
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  logic [WIDTH_BITS-1:0]  plane_width;
  logic [HEIGHT_BITS-1:0] plane_height;
  logic [WEIGHT_BITS-1:0] alpha_weight;
  logic [WIDTH_BITS-1:0]  width_eff;
  logic [HEIGHT_BITS-1:0] height_eff;

  logic [COL_BITS-1:0]    column_count;
  logic [HEIGHT_BITS-1:0] row_count;
  logic                   col_wrap;
  logic                   row_wrap;
  logic                   in_xfer;
  logic                   cfg_xfer;

  logic signed [SAMPLE_BITS-1:0] upper_line [MAX_WIDTH];
  logic signed [SAMPLE_BITS-1:0] middle_line [MAX_WIDTH];
  logic signed [SAMPLE_BITS-1:0] upper_q;
  logic signed [SAMPLE_BITS-1:0] middle_q;

  mem_stage_t s1;
  logic       v1, v2, v3;
  logic       rdy1, rdy2, rdy3, rdy_out;
  logic       s1_fire;

  logic signed [SAMPLE_BITS-1:0] north, centre, south, west;

  logic signed [SAMPLE_BITS-1:0] centre_s2;
  logic signed [SUM_BITS-1:0]    sum_s2;
  logic [WEIGHT_BITS-1:0]        a_s2;
  logic [WEIGHT_BITS-1:0]        na_s2;
  logic                          last_s2;
  logic [WEIGHT_BITS-1:0]        a_clamp;

  logic signed [PROD_C_BITS-1:0] prod_c;
  logic signed [PROD_N_BITS-1:0] prod_n;
  logic                          last_s3;

  logic signed [ACC_BITS-1:0]     acc;
  logic signed [SHIFTED_BITS-1:0] shifted;
  logic [SAMPLE_BITS-1:0]         sat_value;

  // configuration
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_width  <= WIDTH_RESET;
      plane_height <= HEIGHT_RESET;
      alpha_weight <= ALPHA_RESET;
    end else if (cfg_xfer) begin
      case (cfg_index)
        REG_PLANE_WIDTH:  plane_width  <= cfg_data[WIDTH_BITS-1:0];
        REG_PLANE_HEIGHT: plane_height <= cfg_data[HEIGHT_BITS-1:0];
        REG_ALPHA_WEIGHT: alpha_weight <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (plane_width < WIDTH_MIN) begin
      width_eff = WIDTH_MIN;
    end else if (plane_width > WIDTH_MAX) begin
      width_eff = WIDTH_MAX;
    end else begin
      width_eff = plane_width;
    end
    height_eff = (plane_height < HEIGHT_MIN) ? HEIGHT_MIN : plane_height;
    a_clamp    = (alpha_weight > ALPHA_ONE) ? ALPHA_ONE : alpha_weight;
  end

  // handshake chain; empty stages accept even while the output waits
  assign rdy_out  = ~m_tvalid | m_tready;
  assign rdy3     = ~v3 | rdy_out;
  assign rdy2     = ~v2 | rdy3;
  assign rdy1     = ~v1 | rdy2;
  assign s_tready = rdy1;
  assign in_xfer  = s_tvalid & s_tready;
  assign s1_fire  = v1 & rdy2;

  // raster position
  assign col_wrap = ({1'b0, column_count} + 11'd1) >= width_eff;
  assign row_wrap = ({1'b0, row_count} + 17'd1) >= {1'b0, height_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_xfer &&
                 (cfg_index == REG_PLANE_WIDTH || cfg_index == REG_PLANE_HEIGHT)) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_xfer) begin
      if (col_wrap) begin
        column_count <= '0;
        row_count    <= row_wrap ? '0 : row_count + 16'd1;
      end else begin
        column_count <= column_count + 10'd1;
      end
    end
  end

  // line buffers; a column comes back only after width >= 3 samples, so the
  // upper write from stage 1 never meets a pending read of the same entry
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      middle_line[column_count] <= s_tdata;
      middle_q                  <= middle_line[column_count];
      upper_q                   <= upper_line[column_count];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      upper_line[s1.col] <= middle_q;
    end
  end

  // stage 1: sample waits for read data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1.bottom  <= s_tdata;
      s1.col     <= column_count;
      s1.produce <= (row_count >= 16'd2) && (column_count >= 10'd2);
      s1.last    <= (row_count == height_eff - 16'd1) &&
                    ({1'b0, column_count} == width_eff - 11'd1);
    end
  end

  // window: north/centre/south hold column c-1, west is centre of column c-2
  always_ff @(posedge clk) begin
    if (rst) begin
      north  <= '0;
      centre <= '0;
      south  <= '0;
      west   <= '0;
    end else if (s1_fire) begin
      west   <= centre;
      north  <= upper_q;
      centre <= middle_q;
      south  <= s1.bottom;
    end
  end

  // stage 2: operands
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= s1_fire & s1.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      centre_s2 <= centre;
      sum_s2    <= SUM_BITS'(north) + SUM_BITS'(south) + SUM_BITS'(middle_q) +
                   SUM_BITS'(west);
      a_s2      <= a_clamp;
      na_s2     <= ALPHA_ONE - a_clamp;
      last_s2   <= s1.last;
    end
  end

  // stage 3: products
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      prod_c  <= $signed({1'b0, a_s2}) * centre_s2;
      prod_n  <= $signed({1'b0, na_s2}) * sum_s2;
      last_s3 <= last_s2;
    end
  end

  // round toward negative infinity, then saturate
  always_comb begin
    acc     = $signed({prod_c[PROD_C_BITS-1], prod_c, 2'b00}) + ACC_BITS'(prod_n);
    shifted = acc[ACC_BITS-1:FRAC_SHIFT];
    if (shifted[SHIFTED_BITS-1:SAMPLE_BITS-1] == '0 ||
        shifted[SHIFTED_BITS-1:SAMPLE_BITS-1] == '1) begin
      sat_value = shifted[SAMPLE_BITS-1:0];
    end else if (shifted[SHIFTED_BITS-1]) begin
      sat_value = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rdy_out) begin
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && rdy_out) begin
      m_tdata <= sat_value;
      m_tlast <= last_s3;
    end
  end

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, column_count} < width_eff)
    else $error("column count beyond plane width");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    row_count < height_eff)
    else $error("row count beyond plane height");

  a_plane_wrap: assert property (@(posedge clk) disable iff (rst)
    in_xfer && col_wrap && row_wrap |=> column_count == '0 && row_count == '0)
    else $error("counters did not wrap at end of plane");

  a_last_only_valid: assert property (@(posedge clk) disable iff (rst)
    v2 && last_s2 && rdy3 |=> v3 && last_s3)
    else $error("last flag lost between stages");

endmodule
